/* hdl/thpc_pkg.sv */
`default_nettype none
package thpc_pkg;

  // Raw conversion triple, one per input transfer
  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } thp_in_t;

  // Compensated result, one per output transfer
  typedef struct packed {
    logic signed [15:0] temperature;
    logic [24:0]        pressure;
    logic               pressure_valid;
    logic [16:0]        humidity;
  } thp_out_t;

  // Calibration register indexes
  typedef enum logic [2:0] {
    CFG_TEMP      = 3'd0,
    CFG_PRESS_LO  = 3'd1,
    CFG_PRESS_HI  = 3'd2,
    CFG_MIXED     = 3'd3,
    CFG_HUM       = 3'd4
  } cfg_reg_e;

  // Divider word width and number of restoring steps
  localparam int unsigned DIV_W      = 64;
  // Delay line that carries temperature and humidity past the divider
  localparam int unsigned SIDE_DEPTH = 69;
  // Pre-divider pipeline depth and post-divider depth
  localparam int unsigned PRE_DEPTH  = 9;
  localparam int unsigned POST_DEPTH = 4;

  localparam logic signed [24:0] PRESS_MAX = 25'h1FFFFFF;
  localparam logic [16:0]        HUM_MAX   = 17'd102400;

endpackage
`default_nettype wire

/* hdl/thpc_div.sv */
`default_nettype none
module thpc_div
  import thpc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    vld_i,
  input  wire logic signed [DIV_W-1:0] num_i,
  input  wire logic signed [DIV_W-1:0] den_i,
  output logic                         vld_o,
  output logic signed [DIV_W-1:0]      quo_o,
  output logic                         dz_o
);

  logic [DIV_W-1:0] nq_q  [0:DIV_W];
  logic [DIV_W-1:0] rem_q [0:DIV_W];
  logic [DIV_W-1:0] den_q [0:DIV_W];
  logic             neg_q [0:DIV_W];
  logic             dz_q  [0:DIV_W];
  logic             vld_q [0:DIV_W];
  logic [DIV_W-1:0] quo_q;
  logic             dzo_q;
  logic             vldo_q;

  // Valid bits: advance with the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_W; k++) vld_q[k] <= 1'b0;
      vldo_q <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
      for (int k = 1; k <= DIV_W; k++) vld_q[k] <= vld_q[k-1];
      vldo_q <= vld_q[DIV_W];
    end
  end

  // Take magnitudes, one restoring step per stage, then restore the sign
  always_ff @(posedge clk_i) begin
    logic [DIV_W:0] rsh;
    if (en_i) begin
      nq_q[0]  <= num_i[DIV_W-1] ? DIV_W'(-num_i) : num_i;
      den_q[0] <= den_i[DIV_W-1] ? DIV_W'(-den_i) : den_i;
      rem_q[0] <= '0;
      neg_q[0] <= num_i[DIV_W-1] ^ den_i[DIV_W-1];
      dz_q[0]  <= (den_i == '0);
      for (int k = 0; k < DIV_W; k++) begin
        rsh = {rem_q[k], nq_q[k][DIV_W-1]};
        if (rsh >= {1'b0, den_q[k]}) begin
          rem_q[k+1] <= DIV_W'(rsh - {1'b0, den_q[k]});
          nq_q[k+1]  <= {nq_q[k][DIV_W-2:0], 1'b1};
        end else begin
          rem_q[k+1] <= rsh[DIV_W-1:0];
          nq_q[k+1]  <= {nq_q[k][DIV_W-2:0], 1'b0};
        end
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        dz_q[k+1]  <= dz_q[k];
      end
      quo_q <= neg_q[DIV_W] ? DIV_W'(-nq_q[DIV_W]) : nq_q[DIV_W];
      dzo_q <= dz_q[DIV_W];
    end
  end

  assign vld_o = vldo_q;
  assign quo_o = $signed(quo_q);
  assign dz_o  = dzo_q;

endmodule
`default_nettype wire

/* hdl/thp_sensor_compensation.sv */
// Integer compensation of raw temperature, pressure and humidity conversions.
// Input channel: in_valid_i / in_stall_o with one raw triple in in_data_i.
// Output channel: out_valid_o / out_stall_i with the compensated triple in
// out_data_o. A transfer happens on a rising edge with valid high, stall low.
// Calibration words are written over cfg_valid_i / cfg_ready_o with an index
// and 64-bit data; write them only while no item is in flight.
// Throughput: one item per cycle while the receiver does not stall. An item
// passes the pre-divider stages, the 64-step pipelined restoring divider of
// the pressure path and the post-divider stages into the output register.
// Pressure is 0 with pressure_valid low when its divisor is zero.
// Reset clears all valid bits and the calibration registers.
// While the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o is raised; a stall drops and repeats nothing.
`default_nettype none
module thp_sensor_compensation
  import thpc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire thp_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output thp_out_t         out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  // Calibration registers
  logic [47:0] cal_temp_q;
  logic [63:0] cal_press_lo_q;
  logic [63:0] cal_press_hi_q;
  logic [47:0] cal_mixed_q;
  logic [39:0] cal_hum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_temp_q     <= '0;
      cal_press_lo_q <= '0;
      cal_press_hi_q <= '0;
      cal_mixed_q    <= '0;
      cal_hum_q      <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TEMP:     cal_temp_q     <= cfg_data_i[47:0];
        CFG_PRESS_LO: cal_press_lo_q <= cfg_data_i;
        CFG_PRESS_HI: cal_press_hi_q <= cfg_data_i;
        CFG_MIXED:    cal_mixed_q    <= cfg_data_i[47:0];
        CFG_HUM:      cal_hum_q      <= cfg_data_i[39:0];
        default:      ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Coefficient fields, extended to their datapath width
  logic [15:0]        t1;
  logic signed [31:0] t2, t3, h1, h2, h3, h4, h5, h6;
  logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = cal_temp_q[15:0];
  assign t2 = 32'($signed(cal_temp_q[31:16]));
  assign t3 = 32'($signed(cal_temp_q[47:32]));
  assign p1 = $signed({48'b0, cal_press_lo_q[15:0]});
  assign p2 = 64'($signed(cal_press_lo_q[31:16]));
  assign p3 = 64'($signed(cal_press_lo_q[47:32]));
  assign p4 = 64'($signed(cal_press_lo_q[63:48]));
  assign p5 = 64'($signed(cal_press_hi_q[15:0]));
  assign p6 = 64'($signed(cal_press_hi_q[31:16]));
  assign p7 = 64'($signed(cal_press_hi_q[47:32]));
  assign p8 = 64'($signed(cal_press_hi_q[63:48]));
  assign p9 = 64'($signed(cal_mixed_q[15:0]));
  assign h1 = $signed({24'b0, cal_mixed_q[23:16]});
  assign h2 = 32'($signed(cal_mixed_q[39:24]));
  assign h3 = $signed({24'b0, cal_mixed_q[47:40]});
  assign h4 = 32'($signed(cal_hum_q[15:0]));
  assign h5 = 32'($signed(cal_hum_q[31:16]));
  assign h6 = 32'($signed(cal_hum_q[39:32]));

  // Global advance: move when the output register is free or being taken
  logic adv;
  logic out_vld_q;
  thp_out_t out_q;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Valid bits ahead of and behind the divider
  logic vpre_q  [1:PRE_DEPTH];
  logic vpost_q [1:POST_DEPTH];
  logic div_vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= PRE_DEPTH; k++) vpre_q[k] <= 1'b0;
      for (int k = 1; k <= POST_DEPTH; k++) vpost_q[k] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vpre_q[1] <= in_valid_i;
      for (int k = 2; k <= PRE_DEPTH; k++) vpre_q[k] <= vpre_q[k-1];
      vpost_q[1] <= div_vld;
      for (int k = 2; k <= POST_DEPTH; k++) vpost_q[k] <= vpost_q[k-1];
      out_vld_q <= vpost_q[POST_DEPTH];
    end
  end

  // ---------------- temperature path ----------------
  logic signed [31:0] s1_a_q, s1_d_q, s2_m1_q, s2_dd_q, s3_v1_q, s3_m2_q, s4_tf_q;
  logic [15:0]        s1_ah_q, s2_ah_q, s3_ah_q, s4_ah_q;
  logic [19:0]        ap_q [1:7];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_a_q  <= $signed({15'b0, in_data_i.raw_temp[19:3]}) - $signed({15'b0, t1, 1'b0});
      s1_d_q  <= $signed({16'b0, in_data_i.raw_temp[19:4]}) - $signed({16'b0, t1});
      s1_ah_q <= in_data_i.raw_hum;
      ap_q[1] <= in_data_i.raw_press;
      for (int k = 2; k <= 7; k++) ap_q[k] <= ap_q[k-1];
      s2_m1_q <= s1_a_q * t2;
      s2_dd_q <= s1_d_q * s1_d_q;
      s2_ah_q <= s1_ah_q;
      s3_v1_q <= s2_m1_q >>> 11;
      s3_m2_q <= (s2_dd_q >>> 12) * t3;
      s3_ah_q <= s2_ah_q;
      s4_tf_q <= s3_v1_q + (s3_m2_q >>> 14);
      s4_ah_q <= s3_ah_q;
    end
  end

  // Round and saturate temperature
  logic signed [31:0] tr;
  logic signed [15:0] tout;
  assign tr = (s4_tf_q * 32'sd5 + 32'sd128) >>> 8;
  always_comb begin
    if (tr < -32'sd32768)     tout = 16'sh8000;
    else if (tr > 32'sd32767) tout = 16'sh7FFF;
    else                      tout = tr[15:0];
  end

  // ---------------- humidity path ----------------
  logic signed [31:0] hr;
  logic signed [31:0] h1_h5r_q, h1_rh6_q, h1_rh3_q, h2_x_q, h2_yp_q, h3_x_q, h3_yq_q;
  logic signed [31:0] h4_rr_q, h5_rr_q, h5_sq_q, h6_rr_q, h6_t_q;
  logic [15:0]        h1_ah_q;
  logic signed [15:0] tq_q [1:6];
  logic signed [31:0] hy;

  assign hr = s4_tf_q - 32'sd76800;
  assign hy = (h3_yq_q + 32'sd8192) >>> 14;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tq_q[1] <= tout;
      for (int k = 2; k <= 6; k++) tq_q[k] <= tq_q[k-1];
      h1_h5r_q <= h5 * hr;
      h1_rh6_q <= hr * h6;
      h1_rh3_q <= hr * h3;
      h1_ah_q  <= s4_ah_q;
      h2_x_q   <= (($signed({16'b0, h1_ah_q}) <<< 14) - (h4 <<< 20) - h1_h5r_q
                   + 32'sd16384) >>> 15;
      h2_yp_q  <= (h1_rh6_q >>> 10) * ((h1_rh3_q >>> 11) + 32'sd32768);
      h3_x_q   <= h2_x_q;
      h3_yq_q  <= ((h2_yp_q >>> 10) + 32'sd2097152) * h2;
      h4_rr_q  <= h3_x_q * hy;
      h5_rr_q  <= h4_rr_q;
      h5_sq_q  <= (h4_rr_q >>> 15) * (h4_rr_q >>> 15);
      h6_rr_q  <= h5_rr_q;
      h6_t_q   <= (h5_sq_q >>> 7) * h1;
    end
  end

  // Final humidity correction and clamp
  logic signed [31:0] hfin;
  logic [16:0]        hout;
  assign hfin = h6_rr_q - (h6_t_q >>> 4);
  always_comb begin
    if (hfin < 32'sd0)                hout = '0;
    else if (hfin > 32'sd419430400)   hout = HUM_MAX;
    else                              hout = hfin[28:12];
  end

  // Carry temperature and humidity alongside the divider
  logic signed [15:0] side_t_q [0:SIDE_DEPTH-1];
  logic [16:0]        side_h_q [0:SIDE_DEPTH-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_t_q[0] <= tq_q[6];
      side_h_q[0] <= hout;
      for (int k = 1; k < SIDE_DEPTH; k++) begin
        side_t_q[k] <= side_t_q[k-1];
        side_h_q[k] <= side_h_q[k-1];
      end
    end
  end

  // ---------------- pressure path, ahead of the divider ----------------
  logic signed [33:0] q1n;
  logic signed [67:0] q1sq_full;
  logic signed [63:0] p1_q1sq_q, p1_q1p5_q, p1_q1p2_q;
  logic signed [63:0] p2_q2a_q, p2_q1c_q, p2_q1p5_q, p2_q1p2_q;
  logic signed [63:0] p3_q2_q, p3_q1bp_q;
  logic signed [63:0] p4_m_q, p4_num_q;
  logic signed [63:0] p5_den_q, p5_num_q;
  logic signed [63:0] pd;

  assign q1n       = $signed({{2{s4_tf_q[31]}}, s4_tf_q}) - 34'sd128000;
  assign q1sq_full = q1n * q1n;
  assign pd        = 64'sd1048576 - $signed({44'b0, ap_q[7]});

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q1sq_q <= q1sq_full[63:0];
      p1_q1p5_q <= 64'(q1n) * p5;
      p1_q1p2_q <= 64'(q1n) * p2;
      p2_q2a_q  <= p1_q1sq_q * p6;
      p2_q1c_q  <= p1_q1sq_q * p3;
      p2_q1p5_q <= p1_q1p5_q;
      p2_q1p2_q <= p1_q1p2_q;
      p3_q2_q   <= p2_q2a_q + (p2_q1p5_q <<< 17) + (p4 <<< 35);
      p3_q1bp_q <= (p2_q1c_q >>> 8) + (p2_q1p2_q <<< 12);
      p4_m_q    <= (64'sh0000800000000000 + p3_q1bp_q) * p1;
      p4_num_q  <= (pd <<< 31) - p3_q2_q;
      p5_den_q  <= p4_m_q >>> 33;
      p5_num_q  <= p4_num_q * 64'sd3125;
    end
  end

  // Pipelined signed divider
  logic signed [63:0] div_quo;
  logic               div_dz;

  thpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (vpre_q[PRE_DEPTH]),
    .num_i  (p5_num_q),
    .den_i  (p5_den_q),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .dz_o   (div_dz)
  );

  // ---------------- pressure path, behind the divider ----------------
  logic signed [63:0] d1_p_q, d1_s_q, d1_e2_q, d1_ps9_q;
  logic signed [63:0] d2_p_q, d2_e2_q, d3_p_q, d3_e2_q, d3_e1_q;
  logic [63:0]        d2_ll_q;
  logic [31:0]        d2_lh_q, d2_hl_q;
  logic               d1_dz_q, d2_dz_q, d3_dz_q;
  logic signed [63:0] pf;
  logic [24:0]        pout;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_p_q   <= div_quo;
      d1_s_q   <= div_quo >>> 13;
      d1_e2_q  <= p8 * div_quo;
      d1_ps9_q <= p9 * (div_quo >>> 13);
      d1_dz_q  <= div_dz;
      d2_ll_q  <= {32'b0, d1_ps9_q[31:0]} * {32'b0, d1_s_q[31:0]};
      d2_lh_q  <= d1_ps9_q[31:0] * d1_s_q[63:32];
      d2_hl_q  <= d1_ps9_q[63:32] * d1_s_q[31:0];
      d2_p_q   <= d1_p_q;
      d2_e2_q  <= d1_e2_q;
      d2_dz_q  <= d1_dz_q;
      d3_e1_q  <= $signed(d2_ll_q + {d2_lh_q + d2_hl_q, 32'b0});
      d3_p_q   <= d2_p_q;
      d3_e2_q  <= d2_e2_q;
      d3_dz_q  <= d2_dz_q;
    end
  end

  // Final pressure correction and clamp
  assign pf = ((d3_p_q + (d3_e1_q >>> 25) + (d3_e2_q >>> 19)) >>> 8) + (p7 <<< 4);
  always_comb begin
    if (d3_dz_q || pf < 64'sd0)       pout = '0;
    else if (pf > 64'sd33554431)      pout = PRESS_MAX;
    else                              pout = pf[24:0];
  end

  // Result stage and output register
  thp_out_t d4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d4_q.temperature    <= side_t_q[SIDE_DEPTH-2];
      d4_q.humidity       <= side_h_q[SIDE_DEPTH-2];
      d4_q.pressure       <= pout;
      d4_q.pressure_valid <= !d3_dz_q;
      out_q               <= d4_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Checks
  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |-> in_stall_o)
    else $error("input taken while result held");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.pressure_valid |-> out_q.pressure == '0)
    else $error("pressure not zero on zero divisor");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.humidity <= HUM_MAX)
    else $error("humidity above clamp");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(out_q))
    else $error("stalled result lost");

endmodule
`default_nettype wire

/* sim/thp_sensor_compensation_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module thp_sensor_compensation_tb;
  import thpc_pkg::*;

  localparam int unsigned LATENCY = 80;

  // Fixed-point predictor of the compensation formulas
  class thp_scoreboard;
    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [47:0] cal_mixed;
    logic [39:0] cal_hum;
    thp_out_t    pending[$];
    int          mismatches;

    function new();
      cal_temp = '0;
      cal_press_lo = '0;
      cal_press_hi = '0;
      cal_mixed = '0;
      cal_hum = '0;
      mismatches = 0;
    endfunction

    function void write_cal(cfg_reg_e idx, logic [63:0] data);
      case (idx)
        CFG_TEMP:     cal_temp = data[47:0];
        CFG_PRESS_LO: cal_press_lo = data;
        CFG_PRESS_HI: cal_press_hi = data;
        CFG_MIXED:    cal_mixed = data[47:0];
        CFG_HUM:      cal_hum = data[39:0];
        default: ;
      endcase
    endfunction

    function thp_out_t compensate(thp_in_t raw);
      thp_out_t res;
      logic signed [31:0] at, ah, t1, t2, t3, h1, h2, h3, h4, h5, h6;
      logic signed [31:0] v1, dt, v2, tf, tr, r, x, y, rs;
      logic signed [63:0] ap, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] q1, q2, q1b, p, s, e1, e2, num, mq;
      logic [63:0] ma, mb;
      at = {12'd0, raw.raw_temp};
      ap = {44'd0, raw.raw_press};
      ah = {16'd0, raw.raw_hum};
      t1 = {16'd0, cal_temp[15:0]};
      t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
      t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
      p1 = {48'd0, cal_press_lo[15:0]};
      p2 = {{48{cal_press_lo[31]}}, cal_press_lo[31:16]};
      p3 = {{48{cal_press_lo[47]}}, cal_press_lo[47:32]};
      p4 = {{48{cal_press_lo[63]}}, cal_press_lo[63:48]};
      p5 = {{48{cal_press_hi[15]}}, cal_press_hi[15:0]};
      p6 = {{48{cal_press_hi[31]}}, cal_press_hi[31:16]};
      p7 = {{48{cal_press_hi[47]}}, cal_press_hi[47:32]};
      p8 = {{48{cal_press_hi[63]}}, cal_press_hi[63:48]};
      p9 = {{48{cal_mixed[15]}}, cal_mixed[15:0]};
      h1 = {24'd0, cal_mixed[23:16]};
      h2 = {{16{cal_mixed[39]}}, cal_mixed[39:24]};
      h3 = {24'd0, cal_mixed[47:40]};
      h4 = {{16{cal_hum[15]}}, cal_hum[15:0]};
      h5 = {{16{cal_hum[31]}}, cal_hum[31:16]};
      h6 = {{24{cal_hum[39]}}, cal_hum[39:32]};

      // temperature, wrapping 32-bit arithmetic
      v1 = (((at >>> 3) - (t1 <<< 1)) * t2) >>> 11;
      dt = (at >>> 4) - t1;
      v2 = (((dt * dt) >>> 12) * t3) >>> 14;
      tf = v1 + v2;
      tr = (tf * 5 + 128) >>> 8;
      if (tr < -32768) res.temperature = 16'sh8000;
      else if (tr > 32767) res.temperature = 16'sh7FFF;
      else res.temperature = tr[15:0];

      // pressure, wrapping 64-bit arithmetic
      q1 = 64'(tf) - 128000;
      q2 = q1 * q1 * p6;
      q2 = q2 + ((q1 * p5) <<< 17);
      q2 = q2 + (p4 <<< 35);
      q1b = ((q1 * q1 * p3) >>> 8) + ((q1 * p2) <<< 12);
      q1b = (((64'sd1 <<< 47) + q1b) * p1) >>> 33;
      res.pressure = '0;
      res.pressure_valid = 1'b0;
      if (q1b != 0) begin
        num = (((64'sd1048576 - ap) <<< 31) - q2) * 3125;
        ma = num[63] ? -num : num;
        mb = q1b[63] ? -q1b : q1b;
        mq = ma / mb;
        p = (num[63] != q1b[63]) ? -mq : mq;
        s = p >>> 13;
        e1 = (p9 * s * s) >>> 25;
        e2 = (p8 * p) >>> 19;
        p = ((p + e1 + e2) >>> 8) + (p7 <<< 4);
        if (p < 0) res.pressure = '0;
        else if (p > 64'sh1FFFFFF) res.pressure = 25'h1FFFFFF;
        else res.pressure = p[24:0];
        res.pressure_valid = 1'b1;
      end

      // humidity, wrapping 32-bit arithmetic
      r = tf - 76800;
      x = (((ah <<< 14) - (h4 <<< 20) - h5 * r) + 16384) >>> 15;
      y = (((r * h6) >>> 10) * (((r * h3) >>> 11) + 32768)) >>> 10;
      y = ((y + 2097152) * h2 + 8192) >>> 14;
      r = x * y;
      rs = r >>> 15;
      r = r - ((((rs * rs) >>> 7) * h1) >>> 4);
      if (r < 0) res.humidity = '0;
      else if (r > 419430400) res.humidity = 17'(419430400 >>> 12);
      else res.humidity = 17'(r >>> 12);
      return res;
    endfunction

    function void note_input(thp_in_t raw);
      pending.push_back(compensate(raw));
    endfunction

    function void check_result(thp_out_t got);
      thp_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.temperature !== want.temperature || got.pressure !== want.pressure ||
          got.pressure_valid !== want.pressure_valid || got.humidity !== want.humidity) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected t=%0d p=%0d v=%0b h=%0d, got t=%0d p=%0d v=%0b h=%0d",
                   want.temperature, want.pressure, want.pressure_valid, want.humidity,
                   got.temperature, got.pressure, got.pressure_valid, got.humidity);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  thp_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  thp_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        send_done = 1'b0;

  thp_scoreboard sb = new();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  thp_sensor_compensation u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // Note input transfers and check output transfers at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random receiver stalls, with calm stretches
  initial begin
    int n;
    forever begin
      @(negedge clk);
      n = gap_len();
      if (n > 0 && !send_done && ($urandom_range(0, 3) != 0)) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_cal(cfg_reg_e idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_cal(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the item until its transfer
  task automatic send_item(thp_in_t raw, bit allow_gap);
    int n;
    n = allow_gap ? gap_len() : 0;
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= raw;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic thp_in_t rand_raw();
    thp_in_t raw;
    raw.raw_temp = 20'($urandom);
    raw.raw_press = 20'($urandom);
    raw.raw_hum = 16'($urandom);
    return raw;
  endfunction

  // Calibration near a typical sensor, with random jitter when asked
  task automatic load_typical(bit jitter);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(0, 63)) : 16'd0;
    write_cal(CFG_TEMP, {16'(-16'sd1000 + j), 16'(16'sd26500 + j), 16'd27500 + j});
    write_cal(CFG_PRESS_LO, {16'(16'sd7000 + j), 16'(16'sd3000 + j),
                             16'(-16'sd10500 - j), 16'd36500 + j});
    write_cal(CFG_PRESS_HI, {16'(16'sd3500 + j), 16'(16'sd15500 - j),
                             16'(-16'sd7 - j), 16'sd140 + j});
    write_cal(CFG_MIXED, {8'd0, 16'sd360 + j, 8'd75, 16'(16'sd6000 + j)});
    write_cal(CFG_HUM, {24'd0, 8'd30, 16'(16'sd50 + j[5:0])});
  endtask

  initial begin
    thp_in_t raw;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Calibration all zero: divisor zero, pressure flagged invalid
    send_item('0, 0);
    send_item('1, 0);
    drain();

    // Typical calibration, directed extremes, then random items
    load_typical(0);
    send_item('0, 0);
    send_item('1, 0);
    send_item({20'd519888, 20'd415148, 16'd27000}, 0);
    send_item({20'hFFFFF, 20'd0, 16'hFFFF}, 0);
    send_item({20'd0, 20'hFFFFF, 16'd0}, 0);
    send_item({20'h80000, 20'h80000, 16'h8000}, 0);
    send_item({20'h7FFFF, 20'h7FFFF, 16'h7FFF}, 0);
    send_item({20'h55555, 20'hAAAAA, 16'h5555}, 0);
    send_item({20'hAAAAA, 20'h55555, 16'hAAAA}, 0);
    repeat (100) send_item(rand_raw(), 1);
    drain();

    // Extreme calibration words, saturation and clamping
    write_cal(CFG_TEMP, {64{1'b1}});
    write_cal(CFG_PRESS_LO, {64{1'b1}});
    write_cal(CFG_PRESS_HI, {64{1'b1}});
    write_cal(CFG_MIXED, {64{1'b1}});
    write_cal(CFG_HUM, {64{1'b1}});
    send_item('0, 0);
    send_item('1, 0);
    repeat (40) send_item(rand_raw(), 1);
    drain();

    write_cal(CFG_TEMP, {16'h8000, 16'h7FFF, 16'hFFFF});
    write_cal(CFG_PRESS_LO, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
    write_cal(CFG_PRESS_HI, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    write_cal(CFG_MIXED, 64'h00FF_7FFF_FF80_00);
    write_cal(CFG_HUM, 64'h80_8000_7FFF);
    send_item('0, 0);
    send_item('1, 0);
    repeat (40) send_item(rand_raw(), 1);
    drain();

    // Fully random calibration
    write_cal(CFG_TEMP, {$urandom, $urandom});
    write_cal(CFG_PRESS_LO, {$urandom, $urandom});
    write_cal(CFG_PRESS_HI, {$urandom, $urandom});
    write_cal(CFG_MIXED, {$urandom, $urandom});
    write_cal(CFG_HUM, {$urandom, $urandom});
    repeat (60) send_item(rand_raw(), 1);
    drain();

    // Plausible calibrations, mostly back to back
    repeat (3) begin
      load_typical(1);
      repeat (70) begin
        raw = rand_raw();
        if ($urandom_range(0, 1)) raw.raw_temp = 20'($urandom_range(400000, 650000));
        send_item(raw, $urandom_range(0, 2) == 0);
      end
      drain();
    end

    send_done <= 1'b1;
    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Give up long after the slowest correct run
  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
hdl/thpc_pkg.sv
hdl/thpc_div.sv
hdl/thp_sensor_compensation.sv
sim/thp_sensor_compensation_tb.sv
